// ===== rtl/wsfd_pkg.sv =====
// Package for the websocket frame decoder: types, codes and reset constants.
`default_nettype none
package wsfd_pkg;

	localparam int unsigned LenW = 64;
	localparam int unsigned MaxLenW = 63;
	localparam logic [MaxLenW-1:0] MaxPayloadReset = MaxLenW'(64'd536870912);

	typedef enum logic [2:0] {
		PH_HDR0    = 3'd0,
		PH_HDR1    = 3'd1,
		PH_EXTLEN  = 3'd2,
		PH_KEY     = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_CLOSED  = 3'd5
	} phase_t;

	localparam logic [3:0] OP_CONT  = 4'h0;
	localparam logic [3:0] OP_TEXT  = 4'h1;
	localparam logic [3:0] OP_BIN   = 4'h2;
	localparam logic [3:0] OP_CLOSE = 4'h8;
	localparam logic [3:0] OP_PING  = 4'h9;

	localparam logic [1:0] CLS_DATA  = 2'd0;
	localparam logic [1:0] CLS_PING  = 2'd1;
	localparam logic [1:0] CLS_CLOSE = 2'd2;
	localparam logic [1:0] CLS_OVER  = 2'd3;

	localparam logic [1:0] MT_NONE = 2'd0;

	localparam logic [6:0] LEN7_EXT16 = 7'd126;
	localparam logic [6:0] LEN7_EXT64 = 7'd127;
	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [3:0] KEY_BYTES   = 4'd4;

	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic       has_byte;
		logic [1:0] cls;
		logic [1:0] mt;
		logic       last;
	} res_t;

endpackage
`default_nettype wire

// ===== rtl/wsfd_in_stage.sv =====
// Input register stage: holds one received byte until the parser takes it.
`default_nettype none
module wsfd_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       take,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);
	always_comb begin
		in_ready = !valid_s1 || take;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/wsfd_parser.sv =====
// Frame parser: header, length, mask key and payload state, one byte per beat.
`default_nettype none
module wsfd_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  logic [7:0]        rx_byte,
	input  logic [62:0]       max_len,
	output wsfd_pkg::res_t    res
);
	import wsfd_pkg::*;

	phase_t            phase_q, phase_d;
	logic              fin_q;
	logic [3:0]        op_q;
	logic              masked_q;
	logic [3:0]        left_q;
	logic [LenW-1:0]   rem_q;
	logic [31:0]       key_q;
	logic [1:0]        kp_q;
	logic [1:0]        mt_q;

	logic              fin_d, masked_d;
	logic [3:0]        op_d, left_d;
	logic [LenW-1:0]   rem_d;
	logic [31:0]       key_d;
	logic [1:0]        kp_d, mt_d;

	logic [6:0]        len7;
	logic              hdr1_ext, hdr1_short, ext_fin, len_ready, len_over, masked_now;
	logic              key_fin, start_pl, empty_end, pl_end, is_data, go_key;
	logic [LenW-1:0]   ext_len, len_val, pl_len;
	logic [7:0]        key_byte, plain;

	assign len7       = rx_byte[6:0];
	assign hdr1_ext   = (len7 == LEN7_EXT16) || (len7 == LEN7_EXT64);
	assign hdr1_short = (phase_q == PH_HDR1) && !hdr1_ext;
	assign ext_len    = {rem_q[LenW-9:0], rx_byte};
	assign ext_fin    = (phase_q == PH_EXTLEN) && (left_q == 4'd1);
	assign len_ready  = hdr1_short || ext_fin;
	assign len_val    = hdr1_short ? {{(LenW-7){1'b0}}, len7} : ext_len;
	assign len_over   = len_val > {1'b0, max_len};
	assign masked_now = (phase_q == PH_HDR1) ? rx_byte[7] : masked_q;
	assign go_key     = len_ready && !len_over && masked_now;
	assign key_fin    = (phase_q == PH_KEY) && (left_q == 4'd1);
	assign start_pl   = (len_ready && !len_over && !masked_now) || key_fin;
	assign pl_len     = key_fin ? rem_q : len_val;
	assign empty_end  = start_pl && (pl_len == '0);
	assign pl_end     = (phase_q == PH_PAYLOAD) && (rem_q == LenW'(1));
	assign is_data    = (op_q == OP_CONT) || (op_q == OP_TEXT) || (op_q == OP_BIN);

	always_comb begin
		unique case (kp_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
		plain = rx_byte ^ (masked_q ? key_byte : 8'h00);
	end

	// next phase
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_HDR0: phase_d = PH_HDR1;
			PH_HDR1, PH_EXTLEN, PH_KEY: begin
				if (phase_q == PH_HDR1 && hdr1_ext) begin
					phase_d = PH_EXTLEN;
				end
				if (len_ready && len_over) begin
					phase_d = PH_CLOSED;
				end else if (go_key) begin
					phase_d = PH_KEY;
				end else if (start_pl) begin
					if (pl_len != '0) begin
						phase_d = PH_PAYLOAD;
					end else if (op_q == OP_CLOSE) begin
						phase_d = PH_CLOSED;
					end else begin
						phase_d = PH_HDR0;
					end
				end
			end
			PH_PAYLOAD: begin
				if (pl_end) begin
					phase_d = (op_q == OP_CLOSE) ? PH_CLOSED : PH_HDR0;
				end
			end
			PH_CLOSED: phase_d = PH_CLOSED;
			default:   phase_d = PH_HDR0;
		endcase
	end

	// datapath updates and result
	always_comb begin
		fin_d    = fin_q;
		op_d     = op_q;
		masked_d = masked_q;
		left_d   = left_q;
		rem_d    = rem_q;
		key_d    = key_q;
		kp_d     = kp_q;
		mt_d     = mt_q;
		res      = '0;
		unique case (phase_q)
			PH_HDR0: begin
				fin_d = rx_byte[7];
				op_d  = rx_byte[3:0];
				if (rx_byte[3:0] == OP_TEXT || rx_byte[3:0] == OP_BIN) begin
					mt_d = rx_byte[1:0];
				end
			end
			PH_HDR1: begin
				masked_d = rx_byte[7];
				rem_d    = hdr1_ext ? '0 : len_val;
				left_d   = (len7 == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
			end
			PH_EXTLEN: begin
				rem_d  = ext_len;
				left_d = left_q - 4'd1;
			end
			PH_KEY: begin
				key_d  = {key_q[23:0], rx_byte};
				left_d = left_q - 4'd1;
			end
			PH_PAYLOAD: begin
				kp_d  = kp_q + 2'd1;
				rem_d = rem_q - LenW'(1);
				if (is_data) begin
					res = '{valid: 1'b1, data: plain, has_byte: 1'b1, cls: CLS_DATA,
						mt: mt_q, last: pl_end && fin_q};
					if (pl_end && fin_q) begin
						mt_d = MT_NONE;
					end
				end else if (op_q == OP_PING) begin
					res = '{valid: 1'b1, data: plain, has_byte: 1'b1, cls: CLS_PING,
						mt: MT_NONE, last: pl_end};
				end else if (op_q == OP_CLOSE && pl_end) begin
					res = '{valid: 1'b1, data: 8'h00, has_byte: 1'b0, cls: CLS_CLOSE,
						mt: MT_NONE, last: 1'b1};
				end
			end
			default: begin
			end
		endcase

		if (len_ready && len_over) begin
			res = '{valid: 1'b1, data: 8'h00, has_byte: 1'b0, cls: CLS_OVER,
				mt: MT_NONE, last: 1'b1};
		end
		if (go_key) begin
			left_d = KEY_BYTES;
			key_d  = '0;
		end
		if (start_pl) begin
			kp_d = 2'd0;
		end
		// zero-length frame ends right here with no byte to carry the end
		if (empty_end) begin
			if (op_q == OP_CLOSE) begin
				res = '{valid: 1'b1, data: 8'h00, has_byte: 1'b0, cls: CLS_CLOSE,
					mt: MT_NONE, last: 1'b1};
			end else if (op_q == OP_PING) begin
				res = '{valid: 1'b1, data: 8'h00, has_byte: 1'b0, cls: CLS_PING,
					mt: MT_NONE, last: 1'b1};
			end else if (is_data && fin_q) begin
				res = '{valid: 1'b1, data: 8'h00, has_byte: 1'b0, cls: CLS_DATA,
					mt: mt_q, last: 1'b1};
				mt_d = MT_NONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR0;
			fin_q    <= 1'b0;
			op_q     <= '0;
			masked_q <= 1'b0;
			left_q   <= '0;
			rem_q    <= '0;
			key_q    <= '0;
			kp_q     <= '0;
			mt_q     <= MT_NONE;
		end else if (go) begin
			phase_q  <= phase_d;
			fin_q    <= fin_d;
			op_q     <= op_d;
			masked_q <= masked_d;
			left_q   <= left_d;
			rem_q    <= rem_d;
			key_q    <= key_d;
			kp_q     <= kp_d;
			mt_q     <= mt_d;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/wsfd_out_stage.sv =====
// Result register: holds one result beat until the sink takes it.
`default_nettype none
module wsfd_out_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  wsfd_pkg::res_t res,
	output logic           free,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     out_byte,
	output logic [4:0]     out_user,
	output logic           out_last
);
	import wsfd_pkg::*;

	res_t res_q;

	always_comb begin
		free      = !out_valid || out_ready;
		out_byte  = res_q.data;
		out_user  = {res_q.mt, res_q.cls, res_q.has_byte};
		out_last  = res_q.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (free) begin
			out_valid <= load && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load && res.valid) begin
			res_q <= res;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/websocket_frame_decoder_unit.sv =====
// Top level of the websocket frame decoder.
// Decodes a received websocket byte stream at one byte per clock: a byte
// taken on the slave side is registered, parsed once the result register is
// free and its result (if any) is registered on the master side, so a new
// byte can enter every cycle while the sink keeps up. The rate is set by the
// combinational parser update (64-bit length compare and decrement).
// Header and mask-key bytes give no beat, except that the byte that ends an
// empty final data frame or an empty ping gives one byteless end beat; payload
// bytes of data and ping frames give one beat each, and close or over-limit
// events give one byteless beat after which the decoder ignores input until reset.
// max_payload_len (cfg_wdata) resets to 512 MiB and must be written while idle.
`default_nettype none
module websocket_frame_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [62:0] cfg_wdata,   // max_payload_len
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,     // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,     // [7:0] out_byte
	output logic [4:0]  m_tuser,     // [0] has_byte, [2:1] out_class, [4:3] msg_type
	output logic        m_tlast      // last
);
	import wsfd_pkg::*;

	logic [MaxLenW-1:0] max_len_q;
	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic               out_free;
	logic               advance;
	res_t               res;

	assign advance = valid_s1 && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MaxPayloadReset;
		end else if (cfg_wen) begin
			max_len_q <= cfg_wdata;
		end
	end

	wsfd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata),
		.take     (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	wsfd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (advance),
		.rx_byte (byte_s1),
		.max_len (max_len_q),
		.res     (res)
	);

	wsfd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.res       (res),
		.free      (out_free),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_byte  (m_tdata),
		.out_user  (m_tuser),
		.out_last  (m_tlast)
	);
endmodule
`default_nettype wire

// ===== dv/websocket_frame_decoder_unit_tb.sv =====
// Self-checking testbench for the websocket frame decoder: frame stimulus, beat prediction.
module websocket_frame_decoder_unit_tb;
	import wsfd_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int unsigned HOLD_CYCLES = 60;
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam logic [63:0] SHORT_LEN_MAX = 64'd125;
	localparam logic [3:0] OP_PONG = 4'hA;
	localparam logic [3:0] OP_RSVD_DATA = 4'h3;
	localparam logic [3:0] OP_RSVD_CTRL = 4'hF;
	localparam logic [MaxLenW-1:0] LIMIT_MAX = '1;

	typedef enum logic [1:0] {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_enc_t;
	typedef enum logic [1:0] {
		LOCK_CLOSE, LOCK_OVER_SHORT, LOCK_OVER_EXT64, LOCK_OVER_EXT16
	} lock_kind_t;

	typedef struct packed {
		logic [7:0] data;
		logic       has_byte;
		logic [1:0] cls;
		logic [1:0] mt;
		logic       last;
	} beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wen = 1'b0;
	logic [62:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic [4:0] m_tuser;
	logic m_tlast;

	websocket_frame_decoder_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Decoder state mirror
	phase_t ph = PH_HDR0;
	logic fin = 1'b0;
	logic [3:0] op = OP_CONT;
	logic msk = 1'b0;
	logic [3:0] field_left = '0;
	logic [63:0] remain = '0;
	logic [31:0] key = '0;
	logic [1:0] key_idx = '0;
	logic [1:0] mtype = MT_NONE;
	logic [MaxLenW-1:0] limit = MaxPayloadReset;

	beat_t expected_beats[$];
	int errors = 0;
	int bytes_sent = 0;
	int send_idle_pct = 26;
	int recv_idle_pct = 82;
	logic rx_held = 1'b0;
	logic msg_open = 1'b0;
	event hold_rx;

	function automatic void push_beat(logic [7:0] d, logic has, logic [1:0] cls,
		logic [1:0] mt, logic lst);
		expected_beats.insert(expected_beats.size(), beat_t'({d, has, cls, mt, lst}));
	endfunction

	function automatic logic is_data_op(logic [3:0] opc);
		return opc == OP_CONT || opc == OP_TEXT || opc == OP_BIN;
	endfunction

	function automatic void begin_payload();
		key_idx = '0;
		if (remain == 0) begin
			ph = PH_HDR0;
			if (op == OP_CLOSE) begin
				ph = PH_CLOSED;
				push_beat('0, 1'b0, CLS_CLOSE, MT_NONE, 1'b1);
			end else if (op == OP_PING) begin
				push_beat('0, 1'b0, CLS_PING, MT_NONE, 1'b1);
			end else if (is_data_op(op) && fin) begin
				push_beat('0, 1'b0, CLS_DATA, mtype, 1'b1);
				mtype = MT_NONE;
			end
		end else begin
			ph = PH_PAYLOAD;
		end
	endfunction

	// Check the limit before any key byte
	function automatic void length_done();
		if (remain > {1'b0, limit}) begin
			ph = PH_CLOSED;
			push_beat('0, 1'b0, CLS_OVER, MT_NONE, 1'b1);
		end else if (msk) begin
			ph = PH_KEY;
			field_left = KEY_BYTES;
			key = '0;
		end else begin
			begin_payload();
		end
	endfunction

	function automatic void decode_byte(logic [7:0] b);
		logic [7:0] kb;
		logic done;
		case (ph)
		PH_HDR0: begin
			fin = b[7];
			op = b[3:0];
			// text and binary opcodes double as the message type code
			if (op == OP_TEXT || op == OP_BIN)
				mtype = op[1:0];
			ph = PH_HDR1;
		end
		PH_HDR1: begin
			msk = b[7];
			remain = '0;
			if (b[6:0] == LEN7_EXT16) begin
				field_left = EXT16_BYTES;
				ph = PH_EXTLEN;
			end else if (b[6:0] == LEN7_EXT64) begin
				field_left = EXT64_BYTES;
				ph = PH_EXTLEN;
			end else begin
				remain = 64'(b[6:0]);
				length_done();
			end
		end
		PH_EXTLEN: begin
			remain = {remain[55:0], b};
			field_left = field_left - 4'd1;
			if (field_left == 0)
				length_done();
		end
		PH_KEY: begin
			key = {key[23:0], b};
			field_left = field_left - 4'd1;
			if (field_left == 0)
				begin_payload();
		end
		PH_PAYLOAD: begin
			kb = msk ? key[8*(3-key_idx) +: 8] : 8'h00;
			key_idx = key_idx + 2'd1;
			remain = remain - 64'd1;
			done = (remain == 0);
			if (done)
				ph = PH_HDR0;
			if (is_data_op(op)) begin
				push_beat(b ^ kb, 1'b1, CLS_DATA, mtype, done && fin);
				if (done && fin)
					mtype = MT_NONE;
			end else if (op == OP_PING) begin
				push_beat(b ^ kb, 1'b1, CLS_PING, MT_NONE, done);
			end else if (op == OP_CLOSE && done) begin
				ph = PH_CLOSED;
				push_beat('0, 1'b0, CLS_CLOSE, MT_NONE, 1'b1);
			end
		end
		default: ;
		endcase
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		beat_t want, got;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata, m_tuser[0], m_tuser[2:1], m_tuser[4:3], m_tlast};
			if (expected_beats.size() == 0) begin
				$error("unexpected beat: out_byte %0h user %0h last %0b",
					m_tdata, m_tuser, m_tlast);
				errors++;
			end else begin
				want = expected_beats.pop_front();
				check_field("out_byte", want.data, got.data);
				check_field("has_byte", want.has_byte, got.has_byte);
				check_field("out_class", want.cls, got.cls);
				check_field("msg_type", want.mt, got.mt);
				check_field("last", want.last, got.last);
			end
		end
	end

	always @(posedge clk)
		m_tready <= !rx_held && ($urandom_range(99) >= recv_idle_pct);

	always begin
		@(hold_rx);
		rx_held <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_held <= 1'b0;
	end

	initial begin
		for (int n = 0; n < CYCLE_LIMIT; n++)
			@(posedge clk);
		$display("*** FAILED ***");
		$finish;
	end

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata <= 8'($urandom);
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		decode_byte(b);
		bytes_sent++;
	endtask

	// Payload length follows the mirrored parser, so over-limit frames stop at the header
	task automatic send_frame(input logic f, input logic [3:0] opc, input logic [63:0] len,
		input logic masked, input len_enc_t enc, input logic [2:0] rsv, input logic [31:0] k);
		if (enc == LEN_SHORT && len > SHORT_LEN_MAX)
			enc = LEN_EXT16;
		if (enc == LEN_EXT16 && len > 64'hFFFF)
			enc = LEN_EXT64;
		send_byte({f, rsv, opc});
		case (enc)
		LEN_SHORT: send_byte({masked, len[6:0]});
		LEN_EXT16: begin
			send_byte({masked, LEN7_EXT16});
			send_byte(len[15:8]);
			send_byte(len[7:0]);
		end
		default: begin
			send_byte({masked, LEN7_EXT64});
			for (int i = 7; i >= 0; i--)
				send_byte(len[8*i +: 8]);
		end
		endcase
		if (masked)
			for (int i = 3; i >= 0; i--)
				send_byte(k[8*i +: 8]);
		while (ph == PH_PAYLOAD)
			send_byte(8'($urandom));
	endtask

	task automatic wait_for_idle();
		s_tvalid <= 1'b0;
		while (expected_beats.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [MaxLenW-1:0] v);
		wait_for_idle();
		cfg_wen <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		limit = v;
		cfg_wen <= 1'b0;
	endtask

	function automatic logic [3:0] pick_control();
		int r;
		r = $urandom_range(9);
		if (r < 4)
			return OP_PING;
		if (r < 7)
			return OP_PONG;
		return $urandom_range(1) ? 4'($urandom_range(3, 7)) : 4'($urandom_range(11, 15));
	endfunction

	task automatic random_frame();
		int r, n;
		logic [3:0] opc;
		logic f;
		len_enc_t enc;
		logic [31:0] k;
		r = $urandom_range(99);
		if (!msg_open) begin
			if (r < 65)
				opc = $urandom_range(1) ? OP_TEXT : OP_BIN;
			else if (r < 72)
				opc = OP_CONT;
			else
				opc = pick_control();
		end else begin
			if (r < 65)
				opc = OP_CONT;
			else if (r < 75)
				opc = $urandom_range(1) ? OP_TEXT : OP_BIN;
			else
				opc = pick_control();
		end
		if (is_data_op(opc)) begin
			f = 1'($urandom_range(1));
			msg_open = !f;
		end else begin
			f = ($urandom_range(9) != 0);
		end
		r = $urandom_range(99);
		if (r < 60)
			n = $urandom_range(8);
		else if (r < 90)
			n = $urandom_range(9, 125);
		else
			n = $urandom_range(126, 300);
		if (64'(n) > {1'b0, limit})
			n = int'(limit);
		r = $urandom_range(99);
		if (n <= 125)
			enc = r < 80 ? LEN_SHORT : (r < 90 ? LEN_EXT16 : LEN_EXT64);
		else
			enc = r < 85 ? LEN_EXT16 : LEN_EXT64;
		r = $urandom_range(9);
		k = r == 0 ? 32'h0 : (r == 1 ? 32'hFFFF_FFFF : 32'($urandom));
		send_frame(f, opc, 64'(n), 1'($urandom_range(1)), enc, 3'($urandom_range(7)), k);
	endtask

	task automatic test_random_traffic(input int n);
		int target;
		target = bytes_sent + n;
		while (bytes_sent < target)
			random_frame();
	endtask

	task automatic test_data_frames();
		send_frame(1'b1, OP_TEXT, 64'd3, 1'b0, LEN_SHORT, 3'b000, 32'h0);
		send_frame(1'b1, OP_BIN, 64'd4, 1'b1, LEN_SHORT, 3'b000, 32'hFFFF_FFFF);
		// empty final frame gives a byteless end marker; reserved bits ignored
		send_frame(1'b1, OP_TEXT, 64'd0, 1'b0, LEN_SHORT, 3'b111, 32'h0);
	endtask

	task automatic test_fragmentation();
		send_frame(1'b0, OP_TEXT, 64'd2, 1'b1, LEN_SHORT, 3'b000, 32'($urandom));
		send_frame(1'b1, OP_PING, 64'd1, 1'b0, LEN_SHORT, 3'b000, 32'h0);
		send_frame(1'b0, OP_CONT, 64'd0, 1'b0, LEN_SHORT, 3'b000, 32'h0);
		send_frame(1'b1, OP_CONT, 64'd2, 1'b0, LEN_SHORT, 3'b000, 32'h0);
		// continuation with no opening frame carries an unknown type
		send_frame(1'b1, OP_CONT, 64'd1, 1'b0, LEN_SHORT, 3'b000, 32'h0);
		send_frame(1'b0, OP_BIN, 64'd0, 1'b0, LEN_SHORT, 3'b000, 32'h0);
		send_frame(1'b1, OP_CONT, 64'd0, 1'b0, LEN_SHORT, 3'b000, 32'h0);
	endtask

	task automatic test_control_frames();
		send_frame(1'b1, OP_PING, 64'd0, 1'b0, LEN_SHORT, 3'b000, 32'h0);
		send_frame(1'b1, OP_PONG, 64'd2, 1'b1, LEN_SHORT, 3'b000, 32'($urandom));
		send_frame(1'b1, OP_RSVD_CTRL, 64'd1, 1'b1, LEN_EXT64, 3'b111, 32'h0);
		send_frame(1'b1, OP_RSVD_DATA, 64'd0, 1'b0, LEN_SHORT, 3'b000, 32'h0);
	endtask

	task automatic test_length_forms();
		send_frame(1'b1, OP_TEXT, 64'd3, 1'b1, LEN_EXT16, 3'b000, 32'($urandom));
		send_frame(1'b1, OP_BIN, 64'd2, 1'b0, LEN_EXT64, 3'b000, 32'h0);
	endtask

	task automatic test_limit_extremes();
		write_limit('0);
		send_frame(1'b1, OP_TEXT, 64'd0, 1'b0, LEN_SHORT, 3'b000, 32'h0);
		send_frame(1'b1, OP_PING, 64'd0, 1'b1, LEN_SHORT, 3'b000, 32'($urandom));
		// length equal to the limit is still accepted
		write_limit(63'd5);
		send_frame(1'b1, OP_BIN, 64'd5, 1'b1, LEN_EXT16, 3'b000, 32'($urandom));
	endtask

	task automatic test_backpressure();
		wait_for_idle();
		-> hold_rx;
		send_frame(1'b1, OP_BIN, 64'd40, 1'b1, LEN_SHORT, 3'b000, 32'($urandom));
		wait_for_idle();
		-> hold_rx;
		send_frame(1'b1, OP_PING, 64'd30, 1'b0, LEN_SHORT, 3'b000, 32'h0);
		msg_open = 1'b0;
	endtask

	task automatic test_long_frame();
		write_limit(LIMIT_MAX);
		send_frame(1'b1, OP_BIN, 64'd200, 1'b1, LEN_EXT16, 3'b000, 32'($urandom));
	endtask

	// Only one lockout per run: the kind is left to the seed
	task automatic test_lockout();
		lock_kind_t kind;
		int lim;
		kind = lock_kind_t'($urandom_range(3));
		case (kind)
		LOCK_CLOSE:
			send_frame(1'b1, OP_CLOSE, 64'($urandom_range(6)), 1'($urandom_range(1)),
				LEN_SHORT, 3'b000, 32'($urandom));
		LOCK_OVER_SHORT: begin
			lim = $urandom_range(60);
			write_limit(63'(lim));
			send_frame(1'b1, OP_TEXT, 64'($urandom_range(lim + 1, 125)),
				1'($urandom_range(1)), LEN_SHORT, 3'b000, 32'($urandom));
		end
		LOCK_OVER_EXT64:
			send_frame(1'b1, OP_BIN, {1'b1, 31'($urandom), 32'($urandom)},
				1'($urandom_range(1)), LEN_EXT64, 3'b000, 32'($urandom));
		default: begin
			lim = $urandom_range(200);
			write_limit(63'(lim));
			send_frame(1'b1, OP_PING, 64'($urandom_range(300, 65535)),
				1'($urandom_range(1)), LEN_EXT16, 3'b000, 32'($urandom));
		end
		endcase
		// locked: further bytes are dropped
		repeat (6) send_byte(8'($urandom));
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_data_frames();
		test_fragmentation();
		test_control_frames();
		test_length_forms();
		test_limit_extremes();

		write_limit(63'($urandom_range(300, 32'hFFFF_FFFF)));
		test_random_traffic(250);
		test_backpressure();

		send_idle_pct <= 82;
		recv_idle_pct <= 26;
		write_limit(LIMIT_MAX);
		test_random_traffic(250);

		send_idle_pct <= 0;
		recv_idle_pct <= 0;
		write_limit(63'($urandom_range(8, 40)));
		test_random_traffic(250);
		test_long_frame();
		test_lockout();

		wait_for_idle();
		repeat (8) @(posedge clk);
		if (expected_beats.size() != 0) begin
			$error("%0d expected beats never arrived", expected_beats.size());
			errors++;
		end
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/wsfd_pkg.sv
rtl/wsfd_in_stage.sv
rtl/wsfd_parser.sv
rtl/wsfd_out_stage.sv
rtl/websocket_frame_decoder_unit.sv
dv/websocket_frame_decoder_unit_tb.sv
